// ----- rtl/pitr_pkg.sv -----
// Shared widths, register indexes and stage payload type for the PI throttle regulator.
// No dependencies; imported by every rtl module and by the checker.
package pitr_pkg;

    localparam int SPEED_W = 16;              // Q8.8 speed and throttle
    localparam int GAIN_W  = 16;              // Q8.8 gains
    localparam int FRAC_W  = 8;               // fraction bits dropped after each product
    localparam int ERR_W   = SPEED_W + 1;     // signed speed error
    localparam int PPROD_W = GAIN_W + 1 + ERR_W;
    localparam int PTERM_W = GAIN_W + ERR_W - FRAC_W;   // significant bits after shift
    localparam int SUM_W   = 32;              // integral accumulator
    localparam int IPROD_W = GAIN_W + 1 + SUM_W;
    localparam int ITERM_W = IPROD_W - FRAC_W;
    localparam int CMD_W   = ITERM_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MAX  = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST  = 16'd2077;   // ~8.113
    localparam logic [GAIN_W-1:0]  GAIN_I_RST  = 16'd128;    // 0.5
    localparam logic [SPEED_W-1:0] THR_MAX_RST = 16'd11520;  // 45.0

    // Payload from the error/proportional stage to the integral/clamp stage
    typedef struct packed {
        logic                      going_on;
        logic signed [ERR_W-1:0]   err;
        logic signed [PTERM_W-1:0] pterm;
    } pitr_stage_t;

endpackage

// ----- rtl/pitr_front.sv -----
// Input stage: speed error and proportional term, registered.
// Depends on pitr_pkg.
module pitr_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [pitr_pkg::GAIN_W-1:0]  gain_p,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_going_on,
    input  logic [pitr_pkg::SPEED_W-1:0] in_target,
    input  logic [pitr_pkg::SPEED_W-1:0] in_measured,
    output logic                        st_valid,
    input  logic                        st_ready,
    output pitr_pkg::pitr_stage_t       st_data
);
    import pitr_pkg::*;

    logic                      st_valid_reg;
    pitr_stage_t               st_data_reg;
    logic signed [ERR_W-1:0]   err;
    logic signed [PPROD_W-1:0] pprod;

    assign err   = $signed({1'b0, in_target}) - $signed({1'b0, in_measured});
    assign pprod = $signed({1'b0, gain_p}) * err;

    assign in_ready = !st_valid_reg || st_ready;
    assign st_valid = st_valid_reg;
    assign st_data  = st_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            st_valid_reg <= 1'b1;
        end else if (st_ready) begin
            st_valid_reg <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            st_data_reg.going_on <= in_going_on;
            st_data_reg.err      <= err;
            // arithmetic shift by 8 = floor
            st_data_reg.pterm    <= pprod[FRAC_W+PTERM_W-1:FRAC_W];
        end
    end

endmodule

// ----- rtl/pitr_integ.sv -----
// Output stage: anti-windup integral update, integral term, clamp, result register.
// Depends on pitr_pkg.
module pitr_integ (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pitr_pkg::GAIN_W-1:0]  gain_i,
    input  logic [pitr_pkg::SPEED_W-1:0] thr_max,
    input  logic                         st_valid,
    output logic                         st_ready,
    input  pitr_pkg::pitr_stage_t        st_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pitr_pkg::SPEED_W-1:0] out_throttle,
    output logic                         out_saturated
);
    import pitr_pkg::*;

    logic signed [SUM_W-1:0]   sum_reg;
    logic                      last_sat_reg;
    logic                      out_valid_reg;
    logic [SPEED_W-1:0]        throttle_reg;
    logic                      sat_reg;

    logic signed [SUM_W-1:0]   sum_base;
    logic                      hold;
    logic signed [SUM_W:0]     sum_ext;
    logic signed [SUM_W-1:0]   sum_clip;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [IPROD_W-1:0] iprod;
    logic signed [ITERM_W-1:0] iterm;
    logic signed [CMD_W-1:0]   cmd;
    logic signed [CMD_W-1:0]   thr_max_ext;
    logic                      sat_next;
    logic [SPEED_W-1:0]        throttle_next;
    logic                      load;

    assign load     = st_valid && st_ready;
    assign st_ready = !out_valid_reg || out_ready;

    // going on clears the sum and forces the hold
    assign sum_base = st_data.going_on ? '0 : sum_reg;
    assign hold     = st_data.going_on || last_sat_reg;
    assign sum_ext  = {sum_base[SUM_W-1], sum_base}
                    + {{(SUM_W+1-ERR_W){st_data.err[ERR_W-1]}}, st_data.err};

    always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_clip = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_clip = sum_ext[SUM_W-1:0];
        end
    end

    assign sum_next    = hold ? sum_base : sum_clip;
    assign iprod       = $signed({1'b0, gain_i}) * sum_next;
    assign iterm       = iprod[IPROD_W-1:FRAC_W];
    assign cmd         = {{(CMD_W-PTERM_W){st_data.pterm[PTERM_W-1]}}, st_data.pterm}
                       + {iterm[ITERM_W-1], iterm};
    assign thr_max_ext = $signed({{(CMD_W-SPEED_W){1'b0}}, thr_max});

    always_comb begin
        if (cmd > thr_max_ext) begin
            throttle_next = thr_max;
            sat_next      = 1'b1;
        end else if (cmd[CMD_W-1]) begin
            throttle_next = '0;
            sat_next      = 1'b1;
        end else begin
            throttle_next = cmd[SPEED_W-1:0];
            sat_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            last_sat_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                sum_reg      <= sum_next;
                last_sat_reg <= sat_next;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            throttle_reg <= throttle_next;
            sat_reg      <= sat_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_throttle  = throttle_reg;
    assign out_saturated = sat_reg;

endmodule

// ----- rtl/pi_throttle_regulator_core.sv -----
// Top level of the PI throttle regulator: stream ports, configuration registers, two stages.
// Depends on pitr_pkg, pitr_front, pitr_integ.
//
// Cruise-control PI regulator with anti-windup. Each input transfer carries a target and a
// measured speed (unsigned Q8.8) and a going-on flag; each yields exactly one output transfer
// with the clamped throttle and a saturated flag. Throughput is one transfer per clock while
// m_tready is high. Error and proportional product are registered in the first stage;
// integral update, integral product and clamp in the result register. The integral loop
// (held/accumulated sum, gain product, clamp deciding the next hold) sets the rate and
// closes combinationally in stage two. s_tready follows m_tready through both stages
// combinationally. Config index 3 is ignored. The user must write gains and the throttle
// limit via cfg_we/cfg_index/cfg_wdata only while no transfer is in flight (unenforced).
module pi_throttle_regulator_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [pitr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pitr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] target_speed, [31:16] measured_speed
    input  logic [0:0]  s_tuser,   // [0] going_on
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] throttle
    output logic [0:0]  m_tuser    // [0] saturated
);
    import pitr_pkg::*;

    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [SPEED_W-1:0] thr_max_reg;

    logic               st_valid;
    logic               st_ready;
    pitr_stage_t        st_data;

    // config registers, one write per clock, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg  <= GAIN_P_RST;
            gain_i_reg  <= GAIN_I_RST;
            thr_max_reg <= THR_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GAIN_P:  gain_p_reg  <= cfg_wdata;
                CFG_GAIN_I:  gain_i_reg  <= cfg_wdata;
                CFG_THR_MAX: thr_max_reg <= cfg_wdata;
                default: ;   // unknown index: dropped
            endcase
        end
    end

    // stage 1: error and P term
    pitr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .gain_p      (gain_p_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_going_on (s_tuser[0]),
        .in_target   (s_tdata[15:0]),
        .in_measured (s_tdata[31:16]),
        .st_valid    (st_valid),
        .st_ready    (st_ready),
        .st_data     (st_data)
    );

    // stage 2: integral with hold, I term, clamp, result register
    pitr_integ u_integ (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .gain_i        (gain_i_reg),
        .thr_max       (thr_max_reg),
        .st_valid      (st_valid),
        .st_ready      (st_ready),
        .st_data       (st_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_throttle  (m_tdata),
        .out_saturated (m_tuser[0])
    );

endmodule

// ----- rtl/pitr_checker.sv -----
// Port-level checker for pi_throttle_regulator_core, attached by bind.
// Depends on pitr_pkg.
module pitr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                cfg_we,
    input logic [pitr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [pitr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [15:0]                         m_tdata,
    input logic [0:0]                          m_tuser
);
    import pitr_pkg::*;

    logic [SPEED_W-1:0] thr_max_reg;

    // shadow of the throttle limit as seen on the config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_max_reg <= THR_MAX_RST;
        end else if (cfg_we && cfg_index == CFG_THR_MAX) begin
            thr_max_reg <= cfg_wdata;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= thr_max_reg)
        else $error("throttle above limit");

    a_sat_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 || m_tdata == thr_max_reg)
        else $error("saturated result not at a rail");

    a_two_cycle_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && aresetn, 2))
        else $error("result without matching input transfer");

endmodule

bind pi_throttle_regulator_core pitr_checker u_pitr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

// ----- verif/pitr_tb_pkg.sv -----
// Throttle scoreboard for the PI throttle regulator testbench: predicts each command and checks it.
// Depends on pitr_pkg for the register indexes and reset values.
package pitr_tb_pkg;
    import pitr_pkg::*;

    typedef struct {
        bit [15:0] throttle;
        bit        saturated;
    } throttle_cmd_t;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam int     PRINT_CAP = 40;

    class throttle_scoreboard;
        bit [15:0]     gain_p;
        bit [15:0]     gain_i;
        bit [15:0]     thr_max;
        int            integ_sum;
        bit            held_sat;
        throttle_cmd_t pending_cmds[$];
        int unsigned   failures;
        int unsigned   noted;
        int unsigned   checked;
        int unsigned   sum_clips;
        int unsigned   sat_results;

        function new();
            gain_p    = GAIN_P_RST;
            gain_i    = GAIN_I_RST;
            thr_max   = THR_MAX_RST;
            integ_sum = 0;
            held_sat  = 1'b1;
        endfunction

        // unknown indexes leave every register as it was
        function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [15:0] val);
            case (idx)
                CFG_GAIN_P:  gain_p = val;
                CFG_GAIN_I:  gain_i = val;
                CFG_THR_MAX: thr_max = val;
                default: ;
            endcase
        endfunction

        function void note_input(bit going, bit [15:0] tgt, bit [15:0] meas);
            longint        err;
            longint        pterm;
            longint        iterm;
            longint        acc;
            longint        cmd;
            throttle_cmd_t exp_cmd;
            err = longint'(tgt) - longint'(meas);
            if (going) begin
                integ_sum = 0;
                held_sat  = 1'b1;
            end
            pterm = (longint'(gain_p) * err) >>> 8;
            // anti-windup: the sum only moves when the last command was in range
            if (!held_sat) begin
                acc = longint'(integ_sum) + err;
                if (acc > SUM_MAX) begin
                    acc = SUM_MAX;
                    sum_clips++;
                end
                if (acc < SUM_MIN) begin
                    acc = SUM_MIN;
                    sum_clips++;
                end
                integ_sum = int'(acc);
            end
            iterm = (longint'(gain_i) * longint'(integ_sum)) >>> 8;
            cmd = pterm + iterm;
            if (cmd > longint'(thr_max)) begin
                exp_cmd.throttle  = thr_max;
                exp_cmd.saturated = 1'b1;
            end else if (cmd < 0) begin
                exp_cmd.throttle  = '0;
                exp_cmd.saturated = 1'b1;
            end else begin
                exp_cmd.throttle  = cmd[15:0];
                exp_cmd.saturated = 1'b0;
            end
            held_sat = exp_cmd.saturated;
            pending_cmds.push_back(exp_cmd);
            noted++;
        endfunction

        task report(string msg);
            failures++;
            if (failures <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(bit [15:0] thr, bit sat);
            throttle_cmd_t exp_cmd;
            checked++;
            if (pending_cmds.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", checked));
            end else begin
                exp_cmd = pending_cmds.pop_front();
                if (exp_cmd.saturated)
                    sat_results++;
                if (thr !== exp_cmd.throttle)
                    report($sformatf("result %0d throttle %0d, predicted %0d",
                                     checked, thr, exp_cmd.throttle));
                if (sat !== exp_cmd.saturated)
                    report($sformatf("result %0d saturated %0b, predicted %0b",
                                     checked, sat, exp_cmd.saturated));
            end
        endtask

        task drain_check();
            if (pending_cmds.size() != 0)
                report($sformatf("%0d predicted results never came out", pending_cmds.size()));
        endtask
    endclass

endpackage

// ----- verif/tb_pi_throttle_regulator_core.sv -----
// Self-checking testbench for pi_throttle_regulator_core: directed and random runs.
// Depends on pitr_pkg and pitr_tb_pkg (throttle scoreboard); no files or arguments are read.
module tb_pi_throttle_regulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pitr_pkg::*;
    import pitr_tb_pkg::*;

    localparam int                   CLK_HALF    = 6;
    localparam int                   RESET_CYC   = 9;
    localparam int                   CYCLE_LIMIT = 2_000_000;
    localparam int                   HOLD_CYC    = 200;     // long receiver hold-off
    localparam int                   SETTLE_CYC  = 8;       // > two-stage pipeline latency
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;    // no register behind it

    typedef struct {
        bit        going;
        bit [15:0] tgt;
        bit [15:0] meas;
    } speed_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [15:0] target_speed, [31:16] measured_speed
    logic [0:0]            s_tuser   = '0;   // [0] going_on
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // [15:0] throttle
    logic [0:0]            m_tuser;          // [0] saturated

    throttle_scoreboard sb;
    int unsigned        cycle_count = 0;
    int unsigned        input_stalls = 0;
    int unsigned        long_holds = 0;
    int                 burst_left = 0;
    bit                 rand_phase = 1'b0;
    bit                 hold_done = 1'b0;

    pi_throttle_regulator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL pi_throttle_regulator_core");
            $finish;
        end
    end

    // Transfer monitor: both channels are sampled on the rising edge, inputs
    // are noted before results so a same-edge pair stays in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    // Result receiver: segments of always-ready, random and periodic stalls.
    // One long hold-off is forced during the random part, started while the
    // sender is offering, so both stages fill and s_tready drops.
    initial begin : receiver
        int seg_len;
        int style;
        forever begin
            if ((rand_phase && !hold_done && s_tvalid) || $urandom_range(0, 40) == 0) begin
                if (rand_phase)
                    hold_done = 1'b1;
                long_holds++;
                for (int k = 0; k < HOLD_CYC; k++) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                seg_len = $urandom_range(10, 150);
                style   = $urandom_range(0, 3);
                for (int k = 0; k < seg_len; k++) begin
                    @(negedge aclk);
                    case (style)
                        0: m_tready <= 1'b1;
                        1: m_tready <= ($urandom_range(0, 99) < 70);
                        2: m_tready <= (k % 4 == 0);
                        default: m_tready <= ($urandom_range(0, 99) < 25);
                    endcase
                end
            end
        end
    end

    // --- drive tasks ---

    // Present one transfer and hold it until the edge that accepts it.
    task automatic drive_item(input bit going, input bit [15:0] tgt, input bit [15:0] meas);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {meas, tgt};
        s_tuser  <= going;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Sender in bursts: a new burst may open with a gap of idle cycles.
    task automatic send_item(input bit going, input bit [15:0] tgt, input bit [15:0] meas);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        drive_item(going, tgt, meas);
    endtask

    task automatic sender_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Every prediction matched to a result, then a settling wait for the pipeline.
    task automatic wait_drained();
        while (sb.pending_cmds.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Back-to-back register writes; the enable is lowered once at the end.
    task automatic program_regs(input bit [15:0] gp, input bit [15:0] gi, input bit [15:0] tm,
                                input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx_list [4];
        bit   [15:0]          val_list [4];
        int                   n_writes;
        idx_list = '{CFG_GAIN_P, CFG_GAIN_I, CFG_THR_MAX, CFG_UNUSED};
        val_list = '{gp, gi, tm, 16'($urandom)};
        n_writes = poke_unused ? 4 : 3;
        for (int k = 0; k < n_writes; k++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_wdata <= val_list[k];
            @(posedge aclk);
            sb.write_reg(idx_list[k], val_list[k]);
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly small errors around a mid-range speed so the loop stays out of
    // saturation and the integral actually runs; the rest is noise.
    function automatic speed_item_t pick_item();
        speed_item_t it;
        int          r;
        int          off;
        r = $urandom_range(0, 99);
        it.going = 1'b0;
        it.meas  = 16'($urandom_range(16'h0800, 16'hF000));
        if (r < 5) begin
            it.going = 1'b1;
            it.tgt   = 16'($urandom);
            it.meas  = 16'($urandom);
        end else if (r < 70) begin
            off    = int'($urandom_range(0, 800)) - 400;
            it.tgt = 16'(int'(it.meas) + off);
        end else if (r < 85) begin
            off    = int'($urandom_range(0, 8192)) - 4096;
            it.tgt = 16'(int'(it.meas) + off);
        end else begin
            it.tgt  = 16'($urandom);
            it.meas = 16'($urandom);
        end
        return it;
    endfunction

    task automatic run_random_phase(input bit [15:0] gp, input bit [15:0] gi, input bit [15:0] tm,
                                    input bit poke_unused, input int n_items);
        speed_item_t it;
        wait_drained();
        program_regs(gp, gi, tm, poke_unused);
        for (int k = 0; k < n_items; k++) begin
            it = pick_item();
            send_item(it.going, it.tgt, it.meas);
        end
        sender_idle();
    endtask

    // --- main sequence ---
    initial begin : stimulus
        sb = new();
        repeat (RESET_CYC) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values
        send_item(1'b1, 16'h0000, 16'h0000);   // going on: sum cleared, no accumulation
        send_item(1'b0, 16'h0100, 16'h0000);
        send_item(1'b0, 16'h0100, 16'h0100);
        send_item(1'b0, 16'h0000, 16'h0100);   // negative command clamps to zero
        send_item(1'b0, 16'hFFFF, 16'h0000);   // largest positive error
        send_item(1'b0, 16'h0000, 16'hFFFF);   // largest negative error
        send_item(1'b1, 16'hFFFF, 16'hFFFF);
        send_item(1'b0, 16'h8000, 16'h7FFF);
        send_item(1'b0, 16'h7FFF, 16'h8000);
        send_item(1'b0, 16'h1405, 16'h1400);
        send_item(1'b0, 16'h1410, 16'h1400);
        send_item(1'b0, 16'h13F0, 16'h1400);
        send_item(1'b1, 16'h1420, 16'h1400);   // going on while integrating
        send_item(1'b0, 16'h1420, 16'h1400);
        send_item(1'b0, 16'hAAAA, 16'h5555);
        send_item(1'b0, 16'h5555, 16'hAAAA);
        send_item(1'b1, 16'h0000, 16'h0000);
        send_item(1'b0, 16'h0580, 16'h0000);   // proportional term just below the default limit
        send_item(1'b0, 16'h05A0, 16'h0000);   // just above it
        sender_idle();

        // random part over several register settings
        rand_phase = 1'b1;
        run_random_phase(GAIN_P_RST, GAIN_I_RST, THR_MAX_RST, 1'b0, 160);
        run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 150);
        run_random_phase(16'd1000, 16'd300, 16'd0, 1'b0, 150);     // zero throttle limit
        run_random_phase(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 2000)),
                         16'($urandom), 1'b0, 150);
        run_random_phase(16'd0, 16'hFFFF, THR_MAX_RST, 1'b1, 150);
        run_random_phase(16'hFFFF, 16'd0, 16'd256, 1'b0, 150);
        rand_phase = 1'b0;

        wait_drained();
        sb.drain_check();
        $display("run: %0d transfers in, %0d results checked, %0d saturated commands",
                 sb.noted, sb.checked, sb.sat_results);
        $display("run: %0d integral clips, %0d input stall cycles, %0d long receiver holds",
                 sb.sum_clips, input_stalls, long_holds);
        if (sb.failures == 0)
            $display("PASS pi_throttle_regulator_core");
        else
            $display("FAIL pi_throttle_regulator_core");
        $finish;
    end

endmodule
